// ===== rtl/core/fingering_note_deadband_engine_macros.svh =====
// Assertion macros shared by the fingering note engine RTL.
`ifndef FINGERING_NOTE_DEADBAND_ENGINE_MACROS_SVH
`define FINGERING_NOTE_DEADBAND_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FNDE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FNDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fnde_pkg.sv =====
// Types, constants and the fingering table of the fingering note engine.
`default_nettype none
package fnde_pkg;

   localparam int MSG_MAX      = 4;
   localparam int MSG_CNT_W    = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // MIDI status codes
   localparam logic [7:0] ST_NOTE_ON  = 8'h90;
   localparam logic [7:0] ST_NOTE_OFF = 8'h80;
   localparam logic [7:0] ST_POLY_PRS = 8'ha0;
   localparam logic [7:0] ST_CTRL     = 8'hb0;
   localparam logic [7:0] ST_PROGRAM  = 8'hc0;

   // Controller numbers and fixed data values
   localparam logic [6:0] CC_EXPRESSION = 7'h0b;
   localparam logic [6:0] CC_MODULATION = 7'h01;
   localparam logic [7:0] VEL_ON        = 8'h7f;
   localparam logic [7:0] VEL_OFF       = 8'h40;
   localparam logic [7:0] PRS_NEW       = 8'h01;
   localparam logic [7:0] PRS_OLD       = 8'h00;
   localparam logic [7:0] DATA_NONE     = 8'hff;
   localparam logic [7:0] MOD_OFFSET    = 8'd32;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEAD_TIME_UNIT  = 2'd0;
   localparam logic [1:0] CSR_PROGRAM_COUNT   = 2'd1;
   localparam logic [1:0] CSR_TRANSPOSE_LIMIT = 2'd2;

   localparam logic [7:0] RST_DEAD_TIME_UNIT  = 8'd6;
   localparam logic [7:0] RST_PROGRAM_COUNT   = 8'd4;
   localparam logic [3:0] RST_TRANSPOSE_LIMIT = 4'd6;

   // Fingering to note table, indexed by the 6-bit touch pattern
   localparam logic [6:0] NOTE_MAP [64] = '{
      7'h60, 7'h5b, 7'h59, 7'h5d, 7'h58, 7'h5f, 7'h56, 7'h54,
      7'h61, 7'h5c, 7'h5a, 7'h5c, 7'h57, 7'h5e, 7'h57, 7'h55,
      7'h54, 7'h4f, 7'h4d, 7'h51, 7'h4c, 7'h53, 7'h4a, 7'h48,
      7'h55, 7'h50, 7'h4e, 7'h50, 7'h4b, 7'h52, 7'h4b, 7'h49,
      7'h54, 7'h4f, 7'h4d, 7'h51, 7'h4c, 7'h53, 7'h4a, 7'h48,
      7'h55, 7'h50, 7'h4e, 7'h50, 7'h4b, 7'h52, 7'h4b, 7'h49,
      7'h48, 7'h43, 7'h41, 7'h45, 7'h40, 7'h47, 7'h3e, 7'h3c,
      7'h49, 7'h44, 7'h42, 7'h44, 7'h3f, 7'h46, 7'h3f, 7'h3d
   };

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] data_one;
      logic [7:0] data_two;
   } msg_type;

   typedef struct packed {
      msg_type [MSG_MAX-1:0] msg;
      logic [MSG_CNT_W-1:0]  count;
   } bundle_type;

   typedef struct packed {
      logic [7:0] dead_time_unit;
      logic [7:0] program_count;
      logic [3:0] transpose_limit;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/fnde_queue.sv =====
// Short bundle queue between the classifying front and the message back end.
`default_nettype none
module fnde_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire fnde_pkg::bundle_type push_data,
   input  wire                    pop,
   output fnde_pkg::bundle_type   pop_data,
   output fnde_pkg::q_status_type status
);

   fnde_pkg::bundle_type entry_ff [fnde_pkg::QUEUE_DEPTH];
   logic [fnde_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fnde_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fnde_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [fnde_pkg::QUEUE_PTR_W-1:0] LastPtr =
      fnde_pkg::QUEUE_PTR_W'(fnde_pkg::QUEUE_DEPTH - 1);
   localparam logic [fnde_pkg::QUEUE_CNT_W-1:0] FullCount =
      fnde_pkg::QUEUE_CNT_W'(fnde_pkg::QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == FullCount);

endmodule
`default_nettype wire

// ===== rtl/core/fnde_front.sv =====
// Front end: accepts scans and breath events, updates note state, builds messages.
`default_nettype none
module fnde_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_func,
   input  wire  [9:0]           req_sensor_bits,
   input  wire                  req_tick,
   input  wire  [31:0]          req_now_time,
   input  wire  [6:0]           req_expression,
   input  wire fnde_pkg::cfg_type cfg,
   input  wire                  q_full,
   output logic                 q_push,
   output fnde_pkg::bundle_type q_data
);

   logic [5:0]        touch_now_ff, touch_now_in;
   logic [5:0]        touch_before_ff, touch_before_in;
   logic [6:0]        note_last_ff, note_last_in;
   logic [6:0]        tap_ff, tap_in;
   logic [31:0]       wait_start_ff, wait_start_in;
   logic [1:0]        dead_level_ff, dead_level_in;
   logic [6:0]        sounding_ff, sounding_in;
   logic              playing_ff, playing_in;
   logic [6:0]        program_ff, program_in;
   logic signed [4:0] transpose_ff, transpose_in;
   logic [3:0]        buttons_ff, buttons_in;
   fnde_pkg::bundle_type bundle;
   logic              accept;

   function automatic logic [6:0] shift_note(input logic [6:0] note,
                                             input logic signed [4:0] amt);
      shift_note = note + {{2{amt[4]}}, amt};
   endfunction

   function automatic fnde_pkg::msg_type make_msg(input logic [7:0] st,
                                                  input logic [6:0] d1,
                                                  input logic [7:0] d2);
      make_msg.status_byte = st;
      make_msg.data_one    = d1;
      make_msg.data_two    = d2;
   endfunction

   always_comb begin
      logic [fnde_pkg::MSG_CNT_W-1:0] n;
      logic [5:0]        tch;
      logic [5:0]        tb_mid;
      logic [6:0]        cand;
      logic [6:0]        diff;
      logic [31:0]       elapsed;
      logic [9:0]        dead_span;
      logic              take;
      logic [7:0]        cnt_eff;
      logic [7:0]        pn8;
      logic signed [5:0] t6;
      logic signed [5:0] lim6;
      logic [3:0]        nb;

      touch_now_in    = touch_now_ff;
      touch_before_in = touch_before_ff;
      note_last_in    = note_last_ff;
      tap_in          = tap_ff;
      wait_start_in   = wait_start_ff;
      dead_level_in   = dead_level_ff;
      sounding_in     = sounding_ff;
      playing_in      = playing_ff;
      program_in      = program_ff;
      transpose_in    = transpose_ff;
      buttons_in      = buttons_ff;
      bundle          = '0;
      n               = '0;
      take            = 1'b0;
      nb              = req_sensor_bits[9:6];

      for (int i = 0; i < 6; i++) begin
         tch[5-i] = req_sensor_bits[i];
      end
      tb_mid    = (touch_now_ff != tch) ? touch_now_ff : touch_before_ff;
      cand      = fnde_pkg::NOTE_MAP[tch];
      diff      = (cand > note_last_ff) ? cand - note_last_ff : note_last_ff - cand;
      elapsed   = req_now_time - wait_start_ff;
      dead_span = {2'b00, cfg.dead_time_unit} * {8'd0, dead_level_ff};

      if (cfg.program_count == 8'd0) begin
         cnt_eff = 8'd1;
      end else if (cfg.program_count > 8'd128) begin
         cnt_eff = 8'd128;
      end else begin
         cnt_eff = cfg.program_count;
      end
      pn8  = {1'b0, program_ff};
      t6   = {transpose_ff[4], transpose_ff};
      lim6 = {2'b00, cfg.transpose_limit};

      if (req_func) begin
         // Breath event: start or stop the note, then two controllers
         if (!playing_ff && req_expression != 7'd0) begin
            playing_in = 1'b1;
            bundle.msg[n[1:0]] = make_msg(fnde_pkg::ST_NOTE_ON,
                                          shift_note(sounding_ff, transpose_ff),
                                          fnde_pkg::VEL_ON);
            n = n + 1'b1;
         end else if (playing_ff && req_expression == 7'd0) begin
            playing_in = 1'b0;
            bundle.msg[n[1:0]] = make_msg(fnde_pkg::ST_NOTE_OFF,
                                          shift_note(sounding_ff, transpose_ff),
                                          fnde_pkg::VEL_OFF);
            n = n + 1'b1;
         end
         bundle.msg[n[1:0]] = make_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_EXPRESSION,
                                       {1'b0, req_expression});
         n = n + 1'b1;
         bundle.msg[n[1:0]] = make_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_MODULATION,
                                       {4'd0, req_expression[6:3]} + fnde_pkg::MOD_OFFSET);
         n = n + 1'b1;
      end else begin
         touch_now_in    = tch;
         touch_before_in = tb_mid;
         if (req_tick) begin
            if (tch == tb_mid) begin
               // Fingering held: release the note once the dead time ran out
               if (dead_level_ff != 2'd0 && wait_start_ff != 32'd0 &&
                   elapsed > {22'd0, dead_span}) begin
                  take = 1'b1;
               end
            end else begin
               if (dead_level_ff != 2'd0 && tap_ff[6] && tap_ff[5:0] == tch) begin
                  take = 1'b1;
               end else if (diff >= 7'd12) begin
                  wait_start_in = req_now_time;
                  dead_level_in = 2'd3;
                  if (((tch ^ tb_mid) & tch) != 6'd0) begin
                     tap_in = {1'b1, tb_mid};
                  end
               end else if (diff >= 7'd9) begin
                  wait_start_in = req_now_time;
                  dead_level_in = 2'd2;
               end else if (diff >= 7'd3) begin
                  wait_start_in = req_now_time;
                  dead_level_in = 2'd1;
               end else begin
                  take = 1'b1;
               end
               touch_before_in = tch;
            end
            if (take) begin
               note_last_in  = cand;
               tap_in        = '0;
               wait_start_in = '0;
               dead_level_in = '0;
               sounding_in   = cand;
               if (playing_ff) begin
                  if (cand != sounding_ff) begin
                     bundle.msg[0] = make_msg(fnde_pkg::ST_NOTE_ON,
                                              shift_note(cand, transpose_ff),
                                              fnde_pkg::VEL_ON);
                     bundle.msg[1] = make_msg(fnde_pkg::ST_NOTE_OFF,
                                              shift_note(sounding_ff, transpose_ff),
                                              fnde_pkg::VEL_OFF);
                  end else begin
                     bundle.msg[0] = make_msg(fnde_pkg::ST_NOTE_OFF,
                                              shift_note(sounding_ff, transpose_ff),
                                              fnde_pkg::VEL_OFF);
                     bundle.msg[1] = make_msg(fnde_pkg::ST_NOTE_ON,
                                              shift_note(cand, transpose_ff),
                                              fnde_pkg::VEL_ON);
                  end
               end else begin
                  bundle.msg[0] = make_msg(fnde_pkg::ST_POLY_PRS,
                                           shift_note(cand, transpose_ff),
                                           fnde_pkg::PRS_NEW);
                  bundle.msg[1] = make_msg(fnde_pkg::ST_POLY_PRS,
                                           shift_note(sounding_ff, transpose_ff),
                                           fnde_pkg::PRS_OLD);
               end
               n = 3'd2;
            end
         end
         if (!playing_ff) begin
            // Silent: mode buttons step program and transpose
            if (nb != buttons_ff) begin
               if (nb[0]) begin
                  pn8 = (pn8 + 8'd1 >= cnt_eff) ? 8'd0 : pn8 + 8'd1;
                  bundle.msg[n[1:0]] = make_msg(fnde_pkg::ST_PROGRAM, pn8[6:0],
                                                fnde_pkg::DATA_NONE);
                  n = n + 1'b1;
               end
               if (nb[1]) begin
                  pn8 = (pn8 == 8'd0) ? cnt_eff - 8'd1 : pn8 - 8'd1;
                  bundle.msg[n[1:0]] = make_msg(fnde_pkg::ST_PROGRAM, pn8[6:0],
                                                fnde_pkg::DATA_NONE);
                  n = n + 1'b1;
               end
               if (nb[2]) begin
                  t6 = t6 + 6'sd1;
                  if (t6 > lim6) begin
                     t6 = lim6;
                  end
               end
               if (nb[3]) begin
                  t6 = t6 - 6'sd1;
                  if (t6 < -lim6) begin
                     t6 = -lim6;
                  end
               end
            end
            program_in   = pn8[6:0];
            transpose_in = t6[4:0];
            buttons_in   = nb;
         end
      end
      bundle.count = n;
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && (bundle.count != '0);
   assign q_data    = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_now_ff    <= '0;
         touch_before_ff <= '0;
         note_last_ff    <= '0;
         tap_ff          <= '0;
         wait_start_ff   <= '0;
         dead_level_ff   <= '0;
         sounding_ff     <= '0;
         playing_ff      <= 1'b0;
         program_ff      <= '0;
         transpose_ff    <= '0;
         buttons_ff      <= '0;
      end else if (accept) begin
         touch_now_ff    <= touch_now_in;
         touch_before_ff <= touch_before_in;
         note_last_ff    <= note_last_in;
         tap_ff          <= tap_in;
         wait_start_ff   <= wait_start_in;
         dead_level_ff   <= dead_level_in;
         sounding_ff     <= sounding_in;
         playing_ff      <= playing_in;
         program_ff      <= program_in;
         transpose_ff    <= transpose_in;
         buttons_ff      <= buttons_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/fnde_back.sv =====
// Back end: drains a bundle a message per cycle, unless stalled, into the output register.
`default_nettype none
module fnde_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire fnde_pkg::bundle_type q_data,
   input  wire                  q_valid,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [7:0]           rsp_status_byte,
   output logic [6:0]           rsp_data_one,
   output logic [7:0]           rsp_data_two,
   output logic                 rsp_last
);

   fnde_pkg::bundle_type bundle_ff, bundle_in;
   logic                 bvalid_ff, bvalid_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fnde_pkg::msg_type    msg_out_ff, msg_out_in;
   logic                 last_ff, last_in;
   logic                 adv;
   logic                 at_end;

   assign adv    = !rsp_valid_ff || !rsp_stall;
   assign at_end = ({1'b0, idx_ff} == bundle_ff.count - 3'd1);
   assign q_pop  = q_valid && (!bvalid_ff || (adv && at_end));

   always_comb begin
      bundle_in    = bundle_ff;
      bvalid_in    = bvalid_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      msg_out_in   = msg_out_ff;
      last_in      = last_ff;
      if (adv) begin
         rsp_valid_in = bvalid_ff;
         if (bvalid_ff) begin
            msg_out_in = bundle_ff.msg[idx_ff];
            last_in    = at_end;
            if (at_end) begin
               idx_in    = '0;
               bvalid_in = 1'b0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
      if (q_pop) begin
         bundle_in = q_data;
         bvalid_in = 1'b1;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bvalid_ff    <= bvalid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff  <= bundle_in;
      msg_out_ff <= msg_out_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_byte = msg_out_ff.status_byte;
   assign rsp_data_one    = msg_out_ff.data_one;
   assign rsp_data_two    = msg_out_ff.data_two;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/fingering_note_deadband_engine.sv =====
// Top level of the fingering note engine: config registers, front, queue, back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   req_    | in        | req_valid/req_stall| func, sensor_bits, tick, now_time, expression
//   rsp_    | out       | rsp_valid/rsp_stall| status_byte, data_one, data_two, last
//   csr_    | in        | csr_valid/csr_ready| index (2 bit), data (8 bit)
//
// The front classifies a transaction and updates all note state in the cycle it is
// accepted; it takes one transaction per cycle while the two-bundle queue has room.
// The back sends one message per cycle while rsp_stall is low; an item carries 1 to 4
// messages, and an item without messages is taken by the front but never queued.
// Reset is synchronous and clears all control state; config returns to 6, 4, 6.
// rsp_stall holds the output register; req_stall rises only when the queue is full.
`default_nettype none
`include "fingering_note_deadband_engine_macros.svh"
module fingering_note_deadband_engine (
   input  wire         clock,
   input  wire         reset,
   // Input transactions
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_func,
   input  wire  [9:0]  req_sensor_bits,
   input  wire         req_tick,
   input  wire  [31:0] req_now_time,
   input  wire  [6:0]  req_expression,
   // Result transactions
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_status_byte,
   output logic [6:0]  rsp_data_one,
   output logic [7:0]  rsp_data_two,
   output logic        rsp_last,
   // Register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_data
);

   fnde_pkg::cfg_type      cfg_ff, cfg_in;
   fnde_pkg::bundle_type   push_data;
   fnde_pkg::bundle_type   pop_data;
   fnde_pkg::q_status_type q_status;
   logic                   q_push;
   logic                   q_pop;
   logic                   mid_bundle_take;

   // Register writes are always taken; an unknown index is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            fnde_pkg::CSR_DEAD_TIME_UNIT:  cfg_in.dead_time_unit  = csr_data;
            fnde_pkg::CSR_PROGRAM_COUNT:   cfg_in.program_count   = csr_data;
            fnde_pkg::CSR_TRANSPOSE_LIMIT: cfg_in.transpose_limit = csr_data[3:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_time_unit  <= fnde_pkg::RST_DEAD_TIME_UNIT;
         cfg_ff.program_count   <= fnde_pkg::RST_PROGRAM_COUNT;
         cfg_ff.transpose_limit <= fnde_pkg::RST_TRANSPOSE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept, update fingering/dead band/button state, build the bundle
   fnde_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_sensor_bits (req_sensor_bits),
      .req_tick        (req_tick),
      .req_now_time    (req_now_time),
      .req_expression  (req_expression),
      .cfg             (cfg_ff),
      .q_full          (q_status.full),
      .q_push          (q_push),
      .q_data          (push_data)
   );

   // Queue: decouple front acceptance from output stalls
   fnde_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // Back: serialize each bundle onto the result channel
   fnde_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (pop_data),
      .q_valid         (q_status.valid),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status_byte (rsp_status_byte),
      .rsp_data_one    (rsp_data_one),
      .rsp_data_two    (rsp_data_two),
      .rsp_last        (rsp_last)
   );

   // A message other than the last of its bundle is taken this cycle.
   assign mid_bundle_take = rsp_valid && !rsp_stall && !rsp_last;

   // Never push a bundle into a full queue.
   `FNDE_ASSERT_IMPLY(a_no_overflow, clock, reset, q_push, !q_status.full, "queue overflow")
   // Never pop an empty queue.
   `FNDE_ASSERT_IMPLY(a_no_underflow, clock, reset, q_pop, q_status.valid, "queue underflow")
   // Messages of one bundle go out back to back once one is taken.
   `FNDE_ASSERT_NEXT(a_bundle_gapless, clock, reset, mid_bundle_take, rsp_valid, "bundle gap")

endmodule
`default_nettype wire

// ===== sim/tb_fingering_note_deadband_engine.sv =====
// Self-checking testbench for the fingering note engine: directed table, random phases.
`timescale 1ns / 100ps
module tb_fingering_note_deadband_engine;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 50;

   // Unused register slot; writes there must be taken and have no effect.
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   // Fingering to note table, indexed by the 6-bit touch pattern.
   localparam logic [0:63][6:0] FINGER_NOTE = {
      7'h60, 7'h5b, 7'h59, 7'h5d, 7'h58, 7'h5f, 7'h56, 7'h54,
      7'h61, 7'h5c, 7'h5a, 7'h5c, 7'h57, 7'h5e, 7'h57, 7'h55,
      7'h54, 7'h4f, 7'h4d, 7'h51, 7'h4c, 7'h53, 7'h4a, 7'h48,
      7'h55, 7'h50, 7'h4e, 7'h50, 7'h4b, 7'h52, 7'h4b, 7'h49,
      7'h54, 7'h4f, 7'h4d, 7'h51, 7'h4c, 7'h53, 7'h4a, 7'h48,
      7'h55, 7'h50, 7'h4e, 7'h50, 7'h4b, 7'h52, 7'h4b, 7'h49,
      7'h48, 7'h43, 7'h41, 7'h45, 7'h40, 7'h47, 7'h3e, 7'h3c,
      7'h49, 7'h44, 7'h42, 7'h44, 7'h3f, 7'h46, 7'h3f, 7'h3d
   };

   // Key patterns whose notes lie far apart, to provoke dead band waits.
   localparam logic [0:5][5:0] JUMP_KEYS = {6'h00, 6'h3f, 6'h07, 6'h38, 6'h10, 6'h27};

   // Register settings per random phase; extremes and out-of-range counts included.
   localparam logic [0:PHASES-1][7:0] PHASE_DEAD  = {8'd1, 8'd255, 8'd2, 8'd3, 8'd1};
   localparam logic [0:PHASES-1][7:0] PHASE_PROGS = {8'd128, 8'd1, 8'd0, 8'd200, 8'd5};
   localparam logic [0:PHASES-1][3:0] PHASE_LIMIT = {4'd12, 4'd0, 4'd15, 4'd3, 4'd1};

   // One input transaction plus an optional typed-in expectation.
   typedef struct packed {
      logic                        func;
      logic [9:0]                  bits;
      logic                        tick;
      logic [31:0]                 now;
      logic [6:0]                  expr;
      bit                          typed;
      logic [2:0]                  n;
      fnde_pkg::msg_type [2:0]     m;
   } stim_row_type;

   typedef struct packed {
      fnde_pkg::msg_type m;
      logic              last;
   } midi_exp_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [9:0]  req_sensor_bits;
   logic        req_tick;
   logic [31:0] req_now_time;
   logic [6:0]  req_expression;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_status_byte;
   logic [6:0]  rsp_data_one;
   logic [7:0]  rsp_data_two;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   fingering_note_deadband_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_sensor_bits (req_sensor_bits),
      .req_tick        (req_tick),
      .req_now_time    (req_now_time),
      .req_expression  (req_expression),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status_byte (rsp_status_byte),
      .rsp_data_one    (rsp_data_one),
      .rsp_data_two    (rsp_data_two),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #4 clock = ~clock;

   // Predictor copy of the engine state and registers.
   logic [7:0]  cfg_dead_unit;
   logic [7:0]  cfg_prog_count;
   logic [3:0]  cfg_tr_limit;
   logic [5:0]  m_touch_now, m_touch_prev;
   logic [6:0]  m_table_note, m_tap_mem, m_sounding, m_program;
   logic [31:0] m_wait_start;
   logic [1:0]  m_dead_level;
   logic        m_playing;
   logic [3:0]  m_buttons_prev;
   int          m_transpose;

   fnde_pkg::msg_type item_msgs [$];
   midi_exp_type      midi_expected [$];

   stim_row_type dir_tab [0:31];
   int           dir_len = 0;

   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   logic [5:0]  cur_keys, prev_keys;
   logic [31:0] time_units;

   // ---------------------------------------------------------------- predictor

   function automatic logic [6:0] with_transpose(input logic [6:0] note);
      int sum;
      sum = int'(note) + m_transpose;
      return sum[6:0];
   endfunction

   task automatic push_msg(input logic [7:0] st, input logic [6:0] d1, input logic [7:0] d2);
      if (item_msgs.size() < fnde_pkg::MSG_MAX) item_msgs.push_back({st, d1, d2});
   endtask

   // Accept the table note of the present fingering and clear the wait.
   task automatic latch_note(output logic [6:0] nn);
      m_table_note = FINGER_NOTE[m_touch_now];
      m_tap_mem    = '0;
      m_wait_start = '0;
      m_dead_level = '0;
      nn           = m_table_note;
   endtask

   // Per-tick dead band decision; hit reports that a new note was accepted.
   task automatic deadband_check(input logic [31:0] now, output logic [6:0] nn, output bit hit);
      logic [6:0]  cand;
      logic [6:0]  diff;
      logic [31:0] span;
      hit = 1'b0;
      nn  = m_sounding;
      if (m_touch_now == m_touch_prev) begin
         span = now - m_wait_start;
         if (m_dead_level != 0 && m_wait_start != 0 &&
             span > 32'(cfg_dead_unit) * 32'(m_dead_level)) begin
            latch_note(nn);
            hit = 1'b1;
         end
      end else begin
         if (m_dead_level != 0 && m_tap_mem[6] && m_tap_mem[5:0] == m_touch_now) begin
            // going back to the fingering before an octave jump skips the wait
            latch_note(nn);
            hit = 1'b1;
         end else begin
            cand = FINGER_NOTE[m_touch_now];
            diff = (cand > m_table_note) ? cand - m_table_note : m_table_note - cand;
            if (diff >= 12) begin
               m_wait_start = now;
               m_dead_level = 2'd3;
               if (((m_touch_now ^ m_touch_prev) & m_touch_now) != 0)
                  m_tap_mem = {1'b1, m_touch_prev};
            end else if (diff >= 9) begin
               m_wait_start = now;
               m_dead_level = 2'd2;
            end else if (diff >= 3) begin
               m_wait_start = now;
               m_dead_level = 2'd1;
            end else begin
               latch_note(nn);
               hit = 1'b1;
            end
         end
         m_touch_prev = m_touch_now;
      end
   endtask

   // Work out the messages one input transaction causes; leave them in item_msgs.
   task automatic predict_midi(input stim_row_type it);
      logic [5:0] tch;
      logic [6:0] nn;
      logic [3:0] nb;
      bit         hit;
      int         lim;
      int         cnt;
      item_msgs.delete();
      if (it.func) begin
         // breath event: no sensor scan, tick does not matter
         if (!m_playing && it.expr != 0) begin
            m_playing = 1'b1;
            push_msg(fnde_pkg::ST_NOTE_ON, with_transpose(m_sounding), fnde_pkg::VEL_ON);
         end else if (m_playing && it.expr == 0) begin
            m_playing = 1'b0;
            push_msg(fnde_pkg::ST_NOTE_OFF, with_transpose(m_sounding), fnde_pkg::VEL_OFF);
         end
         push_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_EXPRESSION, {1'b0, it.expr});
         push_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_MODULATION,
                  {4'b0, it.expr[6:3]} + fnde_pkg::MOD_OFFSET);
      end else begin
         for (int i = 0; i < 6; i++) tch[5 - i] = it.bits[i];
         if (m_touch_now != tch) begin
            m_touch_prev = m_touch_now;
            m_touch_now  = tch;
         end
         if (it.tick) begin
            deadband_check(it.now, nn, hit);
            if (hit) begin
               if (m_playing) begin
                  if (nn != m_sounding) begin
                     push_msg(fnde_pkg::ST_NOTE_ON, with_transpose(nn), fnde_pkg::VEL_ON);
                     push_msg(fnde_pkg::ST_NOTE_OFF, with_transpose(m_sounding),
                              fnde_pkg::VEL_OFF);
                  end else begin
                     push_msg(fnde_pkg::ST_NOTE_OFF, with_transpose(m_sounding),
                              fnde_pkg::VEL_OFF);
                     push_msg(fnde_pkg::ST_NOTE_ON, with_transpose(nn), fnde_pkg::VEL_ON);
                  end
               end else begin
                  push_msg(fnde_pkg::ST_POLY_PRS, with_transpose(nn), fnde_pkg::PRS_NEW);
                  push_msg(fnde_pkg::ST_POLY_PRS, with_transpose(m_sounding),
                           fnde_pkg::PRS_OLD);
               end
               m_sounding = nn;
            end
         end
         if (!m_playing) begin
            nb  = it.bits[9:6];
            lim = int'(cfg_tr_limit);
            if (nb != m_buttons_prev) begin
               cnt = (cfg_prog_count == 0) ? 1 : (cfg_prog_count > 128) ? 128
                     : int'(cfg_prog_count);
               if (nb[0]) begin
                  m_program = (int'(m_program) + 1 >= cnt) ? 7'd0 : m_program + 7'd1;
                  push_msg(fnde_pkg::ST_PROGRAM, m_program, fnde_pkg::DATA_NONE);
               end
               if (nb[1]) begin
                  m_program = (m_program == 0) ? 7'(cnt - 1) : m_program - 7'd1;
                  push_msg(fnde_pkg::ST_PROGRAM, m_program, fnde_pkg::DATA_NONE);
               end
               // step by one first, then clamp to the present limit
               if (nb[2]) begin
                  m_transpose++;
                  if (m_transpose > lim) m_transpose = lim;
               end
               if (nb[3]) begin
                  m_transpose--;
                  if (m_transpose < -lim) m_transpose = -lim;
               end
            end
            m_buttons_prev = nb;
         end
      end
   endtask

   // ---------------------------------------------------------------- directed table

   task automatic dir_row(input logic func, input logic [9:0] bits, input logic tick,
                          input logic [31:0] now, input logic [6:0] expr);
      stim_row_type r;
      r      = '0;
      r.func = func;
      r.bits = bits;
      r.tick = tick;
      r.now  = now;
      r.expr = expr;
      dir_tab[dir_len] = r;
      dir_len++;
   endtask

   // Type in one expected message for the latest row.
   task automatic dir_msg(input logic [7:0] st, input logic [6:0] d1, input logic [7:0] d2);
      stim_row_type r;
      r           = dir_tab[dir_len - 1];
      r.typed     = 1'b1;
      r.m[r.n]    = {st, d1, d2};
      r.n         = r.n + 3'd1;
      dir_tab[dir_len - 1] = r;
   endtask

   // Latest row is known to cause no message.
   task automatic dir_none();
      stim_row_type r;
      r       = dir_tab[dir_len - 1];
      r.typed = 1'b1;
      dir_tab[dir_len - 1] = r;
   endtask

   // ---------------------------------------------------------------- drivers

   // Enter at a falling edge; hold the payload until taken, return at a falling edge.
   task automatic send_item(input stim_row_type it);
      midi_exp_type e;
      req_valid       <= 1'b1;
      req_func        <= it.func;
      req_sensor_bits <= it.bits;
      req_tick        <= it.tick;
      req_now_time    <= it.now;
      req_expression  <= it.expr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_midi(it);
      // typed-in rows replace the predicted messages; state still advances
      if (it.typed) begin
         item_msgs.delete();
         for (int i = 0; i < it.n; i++) item_msgs.push_back(it.m[i]);
      end
      for (int i = 0; i < item_msgs.size(); i++) begin
         e.m    = item_msgs[i];
         e.last = (i == item_msgs.size() - 1);
         midi_expected.push_back(e);
      end
      @(negedge clock);
   endtask

   // Bursts of random length separated by random gaps; some bursts run back to back.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // Drop valid, wait until every expected message has come, then let the engine settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (midi_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Enter at a falling edge with the engine idle; csr_valid stays up for a following write.
   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         fnde_pkg::CSR_DEAD_TIME_UNIT:  cfg_dead_unit  = val;
         fnde_pkg::CSR_PROGRAM_COUNT:   cfg_prog_count = val;
         fnde_pkg::CSR_TRANSPOSE_LIMIT: cfg_tr_limit   = val[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Mostly well-formed playing: held keys, returns to the previous fingering,
   // octave jumps, button presses; the rest is noise, breath events and time jumps.
   task automatic make_random_item(output stim_row_type it);
      logic [5:0] keys;
      int         pick;
      it   = '0;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         it.func = 1'b1;
         it.expr = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom);
         it.bits = 10'($urandom);
         it.tick = 1'($urandom_range(0, 1));
         it.now  = $urandom;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50)      keys = cur_keys;
         else if (pick < 65) keys = prev_keys;
         else if (pick < 80) keys = JUMP_KEYS[$urandom_range(0, 5)];
         else                keys = 6'($urandom);
         if (keys != cur_keys) begin
            prev_keys = cur_keys;
            cur_keys  = keys;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55)      it.bits[9:6] = 4'b0000;
         else if (pick < 85) it.bits[9:6] = 4'b0001 << $urandom_range(0, 3);
         else                it.bits[9:6] = 4'($urandom);
         it.bits[5:0] = keys;
         it.tick = ($urandom_range(0, 99) < 85);
         pick = $urandom_range(0, 99);
         if (pick < 3)      time_units = $urandom;
         else if (pick < 5) time_units = '0;
         else if (it.tick)  time_units = time_units + 32'($urandom_range(0, 4));
         it.now  = time_units;
         it.expr = 7'($urandom);
      end
   endtask

   // ---------------------------------------------------------------- receiver and checks

   // Stall on a rotating mask that is redrawn at random intervals; a quarter
   // of the windows never stall.
   logic [7:0] stall_mask = 8'h00;
   int         stall_age = 0;
   always @(negedge clock) begin
      if (stall_age == 0) begin
         stall_age  = $urandom_range(16, 64);
         stall_mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      end
      stall_age--;
      stall_mask = {stall_mask[6:0], stall_mask[7]};
      rsp_stall <= stall_mask[0];
   end

   // Compare each taken message with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      midi_exp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (midi_expected.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected message, expected none, actual %h %h %h last %b",
                     $time, rsp_status_byte, rsp_data_one, rsp_data_two, rsp_last);
         end else begin
            want = midi_expected.pop_front();
            if (rsp_status_byte !== want.m.status_byte || rsp_data_one !== want.m.data_one ||
                rsp_data_two !== want.m.data_two || rsp_last !== want.last) begin
               mismatch_count++;
               $display("%0t: message differs, expected %h %h %h last %b, actual %h %h %h last %b",
                        $time, want.m.status_byte, want.m.data_one, want.m.data_two,
                        want.last, rsp_status_byte, rsp_data_one, rsp_data_two, rsp_last);
            end
         end
      end
   end

   // Hard stop in case the engine hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      stim_row_type it;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = 1'b0;
      req_sensor_bits = '0;
      req_tick        = 1'b0;
      req_now_time    = '0;
      req_expression  = '0;
      csr_valid       = 1'b0;
      csr_index       = fnde_pkg::CSR_DEAD_TIME_UNIT;
      csr_data        = '0;

      cfg_dead_unit  = fnde_pkg::RST_DEAD_TIME_UNIT;
      cfg_prog_count = fnde_pkg::RST_PROGRAM_COUNT;
      cfg_tr_limit   = fnde_pkg::RST_TRANSPOSE_LIMIT;
      m_touch_now    = '0;
      m_touch_prev   = '0;
      m_table_note   = '0;
      m_tap_mem      = '0;
      m_sounding     = '0;
      m_program      = '0;
      m_wait_start   = '0;
      m_dead_level   = '0;
      m_playing      = 1'b0;
      m_buttons_prev = '0;
      m_transpose    = 0;

      // Breath at zero while silent: only the two controllers.
      dir_row(1'b1, 10'h000, 1'b0, 32'd0, 7'd0);
      dir_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_EXPRESSION, 8'h00);
      dir_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_MODULATION, fnde_pkg::MOD_OFFSET);
      // Program up, down, held button, release, wrap below zero and above count.
      dir_row(1'b0, 10'h040, 1'b0, 32'd0, 7'd0);
      dir_msg(fnde_pkg::ST_PROGRAM, 7'd1, fnde_pkg::DATA_NONE);
      dir_row(1'b0, 10'h080, 1'b0, 32'd0, 7'd0);
      dir_msg(fnde_pkg::ST_PROGRAM, 7'd0, fnde_pkg::DATA_NONE);
      dir_row(1'b0, 10'h080, 1'b0, 32'd0, 7'd0);
      dir_none();
      dir_row(1'b0, 10'h000, 1'b0, 32'd0, 7'd0);
      dir_none();
      dir_row(1'b0, 10'h080, 1'b0, 32'd0, 7'd0);
      dir_msg(fnde_pkg::ST_PROGRAM, 7'd3, fnde_pkg::DATA_NONE);
      dir_row(1'b0, 10'h040, 1'b0, 32'd0, 7'd0);
      dir_msg(fnde_pkg::ST_PROGRAM, 7'd0, fnde_pkg::DATA_NONE);
      // Transpose up, back down, then below zero.
      dir_row(1'b0, 10'h100, 1'b0, 32'd0, 7'd0);
      dir_none();
      dir_row(1'b0, 10'h000, 1'b0, 32'd0, 7'd0);
      dir_none();
      dir_row(1'b0, 10'h200, 1'b0, 32'd0, 7'd0);
      dir_none();
      dir_row(1'b0, 10'h000, 1'b0, 32'd0, 7'd0);
      dir_none();
      dir_row(1'b0, 10'h200, 1'b0, 32'd0, 7'd0);
      dir_none();
      // Both program buttons at once.
      dir_row(1'b0, 10'h0c0, 1'b0, 32'd0, 7'd0);
      dir_msg(fnde_pkg::ST_PROGRAM, 7'd1, fnde_pkg::DATA_NONE);
      dir_msg(fnde_pkg::ST_PROGRAM, 7'd0, fnde_pkg::DATA_NONE);
      // Full breath with tick set; untouched note 0 shifted down wraps to 127.
      dir_row(1'b1, 10'h000, 1'b1, 32'd0, 7'd127);
      dir_msg(fnde_pkg::ST_NOTE_ON, 7'h7f, fnde_pkg::VEL_ON);
      dir_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_EXPRESSION, 8'h7f);
      dir_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_MODULATION, 8'd47);
      // All buttons while a note sounds: ignored.
      dir_row(1'b0, 10'h3c0, 1'b0, 32'd0, 7'd0);
      dir_none();
      dir_row(1'b1, 10'h000, 1'b0, 32'd0, 7'd0);
      dir_msg(fnde_pkg::ST_NOTE_OFF, 7'h7f, fnde_pkg::VEL_OFF);
      dir_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_EXPRESSION, 8'h00);
      dir_msg(fnde_pkg::ST_CTRL, fnde_pkg::CC_MODULATION, fnde_pkg::MOD_OFFSET);
      // Fingering walk: octave wait, expiry, small step, one-level wait while playing.
      dir_row(1'b0, 10'h03f, 1'b1, 32'd100, 7'd0);
      dir_row(1'b0, 10'h03f, 1'b1, 32'd200, 7'd0);
      dir_row(1'b0, 10'h01f, 1'b1, 32'd201, 7'd0);
      dir_row(1'b1, 10'h000, 1'b0, 32'd0, 7'd64);
      dir_row(1'b0, 10'h027, 1'b1, 32'd210, 7'd0);
      dir_row(1'b0, 10'h027, 1'b1, 32'd217, 7'd0);
      // Wait started at time zero never expires; left by a new fingering.
      dir_row(1'b0, 10'h000, 1'b1, 32'd0, 7'd0);
      dir_row(1'b0, 10'h000, 1'b1, 32'hffff_ffff, 7'd0);
      dir_row(1'b0, 10'h027, 1'b1, 32'd1001, 7'd0);
      // Octave jump with new keys, then a re-tap of the old fingering.
      dir_row(1'b0, 10'h010, 1'b1, 32'd1010, 7'd0);
      dir_row(1'b0, 10'h027, 1'b1, 32'd1011, 7'd0);

      // Hold reset, then release it on a falling edge.
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_len; i++) begin
         pace_sender();
         send_item(dir_tab[i]);
      end

      cur_keys   = 6'h27;
      prev_keys  = 6'h10;
      time_units = 32'd1100;

      for (int p = 0; p < PHASES; p++) begin
         // Registers change only with the engine idle.
         wait_drained();
         csr_write(fnde_pkg::CSR_DEAD_TIME_UNIT, PHASE_DEAD[p]);
         csr_write(fnde_pkg::CSR_PROGRAM_COUNT, PHASE_PROGS[p]);
         csr_write(fnde_pkg::CSR_TRANSPOSE_LIMIT, {4'b0, PHASE_LIMIT[p]});
         if (p == 2) csr_write(CSR_SPARE_INDEX, 8'($urandom));
         csr_valid <= 1'b0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Hold off mid-phase until the output has fully drained.
            if (k == PHASE_ITEMS / 2) wait_drained();
            make_random_item(it);
            pace_sender();
            send_item(it);
         end
      end

      wait_drained();
      if (mismatch_count == 0 && midi_expected.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
